/* rtl/sorted_set_table_macros.svh */
// Assertion macros for the sorted set table checker.
// Used by sst_checker.sv; no other dependencies.
`ifndef SORTED_SET_TABLE_MACROS_SVH
`define SORTED_SET_TABLE_MACROS_SVH

// Same-cycle implication, gated off while reset is high
`define SST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off while reset is high
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sst_pkg.sv */
// Shared types and constants for the sorted set table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sst_pkg;

   localparam int CAPACITY = 64;
   localparam int ELEM_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 2;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_COMMIT
   } state_type;

   // Strobes from the sequencer to the datapath
   typedef struct packed {
      logic accept;
      logic eval;
      logic commit;
   } ctrl_type;

   // Per-cell flags seen by the datapath
   typedef struct packed {
      logic gt;
      logic eq;
      logic hit;
      logic slot;
   } cell_flag_type;

endpackage

/* rtl/sst_cell.sv */
// One storage cell of the sorted set table: entry word plus compare flags.
// Depends on sst_pkg; instantiated in a row by sorted_set_table.
`timescale 1ns / 1ps

module sst_cell (
   input  logic                               clock,
   input  logic                               eval_in,
   input  logic                               shift_in,
   input  logic [sst_pkg::IDX_W-1:0]          cell_idx,
   input  logic [sst_pkg::IDX_W-1:0]          rd_idx,
   input  logic [sst_pkg::CNT_W-1:0]          used,
   input  logic signed [sst_pkg::ELEM_W-1:0]  key,
   input  logic signed [sst_pkg::ELEM_W-1:0]  prev_entry,
   input  logic                               prev_gt,
   output logic signed [sst_pkg::ELEM_W-1:0]  entry,
   output sst_pkg::cell_flag_type             flags
);
   import sst_pkg::*;

   logic signed [ELEM_W-1:0] entry_ff, entry_in;
   logic gt_ff, gt_in;
   logic eq_ff, eq_in;
   logic hit_ff, hit_in;
   logic end_ff, end_in;
   logic live;

   // Compare against the key and the read index
   always_comb begin
      live   = CNT_W'(cell_idx) < used;
      gt_in  = gt_ff;
      eq_in  = eq_ff;
      hit_in = hit_ff;
      end_in = end_ff;
      if (eval_in) begin
         gt_in  = live && (entry_ff > key);
         eq_in  = live && (entry_ff == key);
         hit_in = live && (rd_idx == cell_idx);
         end_in = (used == CNT_W'(cell_idx));
      end
   end

   // Shift up from the lower neighbor, or take the key at the insert slot
   always_comb begin
      entry_in = entry_ff;
      if (shift_in) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt_ff || end_ff) begin
            entry_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
      hit_ff   <= hit_in;
      end_ff   <= end_in;
   end

   assign entry      = entry_ff;
   assign flags.gt   = gt_ff;
   assign flags.eq   = eq_ff;
   assign flags.hit  = hit_ff;
   assign flags.slot = !prev_gt && (gt_ff || end_ff);

endmodule

/* rtl/sst_ctrl.sv */
// Request sequencer for the sorted set table: accept, compare, commit.
// Depends on sst_pkg; instantiated by sorted_set_table.
`timescale 1ns / 1ps

module sst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              slot_free,
   output logic              req_ready,
   output sst_pkg::ctrl_type ctrl
);
   import sst_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EVAL;
         S_EVAL:   state_in = S_COMMIT;
         S_COMMIT: if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Strobes; refuse requests while reset is high
   always_comb begin
      req_ready   = 1'b0;
      ctrl.accept = 1'b0;
      ctrl.eval   = 1'b0;
      ctrl.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = !reset;
            ctrl.accept = req_valid && !reset;
         end
         S_EVAL: begin
            ctrl.eval = 1'b1;
         end
         S_COMMIT: begin
            ctrl.commit = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/sorted_set_table.sv */
// Sorted set table: a request is taken when idle and passes the compare pass
// and the commit pass over the row of storage cells before the next is taken.
// The response is registered at commit; a stalled one holds commit until taken.
// Reset clears the count and the handshake state; entry words are not cleared.
// Depends on sst_pkg, sst_cell and sst_ctrl.
`timescale 1ns / 1ps

module sorted_set_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sst_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [sst_pkg::ELEM_W-1:0] req_value,
   input  logic [sst_pkg::IDX_W-1:0]         req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sst_pkg::STAT_W-1:0]        rsp_status,
   output logic [sst_pkg::IDX_W-1:0]         rsp_position,
   output logic signed [sst_pkg::ELEM_W-1:0] rsp_element,
   output logic [sst_pkg::CNT_W-1:0]         rsp_count
);
   import sst_pkg::*;

   ctrl_type ctrl;
   logic     slot_free;

   logic [KIND_W-1:0]        kind_ff;
   logic signed [ELEM_W-1:0] value_ff;
   logic [IDX_W-1:0]         index_ff;
   logic [CNT_W-1:0]         used_ff, used_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [IDX_W-1:0]         position_ff, position_in;
   logic signed [ELEM_W-1:0] element_ff, element_in;
   logic [CNT_W-1:0]         count_ff;

   logic signed [ELEM_W-1:0] cell_entry [CAPACITY];
   cell_flag_type            cell_flags [CAPACITY];

   logic                     any_eq, any_hit, full, do_insert;
   logic [IDX_W-1:0]         ins_pos, eq_pos;
   logic signed [ELEM_W-1:0] rd_elem;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .slot_free (slot_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // Capture the request
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
         index_ff <= req_index;
      end
   end

   // Row of cells, each handing its entry and gt flag to the next
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [ELEM_W-1:0] prev_entry;
      logic                     prev_gt;
      if (g == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_gt    = 1'b0;
      end else begin : g_rest
         assign prev_entry = cell_entry[g-1];
         assign prev_gt    = cell_flags[g-1].gt;
      end
      sst_cell u_cell (
         .clock      (clock),
         .eval_in    (ctrl.eval),
         .shift_in   (do_insert),
         .cell_idx   (IDX_W'(g)),
         .rd_idx     (index_ff),
         .used       (used_ff),
         .key        (value_ff),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .entry      (cell_entry[g]),
         .flags      (cell_flags[g])
      );
   end

   // Collect the one-hot flags of the row
   always_comb begin
      any_eq  = 1'b0;
      any_hit = 1'b0;
      ins_pos = '0;
      eq_pos  = '0;
      rd_elem = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_eq  = any_eq  | cell_flags[i].eq;
         any_hit = any_hit | cell_flags[i].hit;
         ins_pos = ins_pos | (cell_flags[i].slot ? IDX_W'(i) : '0);
         eq_pos  = eq_pos  | (cell_flags[i].eq   ? IDX_W'(i) : '0);
         rd_elem = rd_elem | (cell_flags[i].hit  ? cell_entry[i] : '0);
      end
   end

   assign full      = (used_ff == CNT_W'(CAPACITY));
   assign do_insert = ctrl.commit && (kind_ff == KIND_INSERT) && !any_eq && !full;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Build the response
   always_comb begin
      status_in   = STAT_MISS;
      position_in = '0;
      element_in  = '0;
      used_in     = used_ff;
      case (kind_ff)
         KIND_INSERT: begin
            if (any_eq) begin
               status_in = STAT_DUP;
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               status_in   = STAT_OK;
               position_in = ins_pos;
               used_in     = used_ff + CNT_W'(1);
            end
         end
         KIND_FIND: begin
            if (any_eq) begin
               status_in   = STAT_OK;
               position_in = eq_pos;
            end
         end
         KIND_READ: begin
            if (any_hit) begin
               status_in  = STAT_OK;
               element_in = rd_elem;
            end
         end
         default: begin
            status_in = STAT_MISS;
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.commit) begin
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         status_ff   <= status_in;
         position_ff <= position_in;
         element_ff  <= element_in;
         count_ff    <= used_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;
   assign rsp_element  = element_ff;
   assign rsp_count    = count_ff;

endmodule

/* rtl/sst_checker.sv */
// Port-level checks for the sorted set table, bound to the top level.
// Depends on sst_pkg and sorted_set_table_macros.svh.
`timescale 1ns / 1ps
`include "sorted_set_table_macros.svh"

module sst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [sst_pkg::KIND_W-1:0]        req_kind,
   input logic signed [sst_pkg::ELEM_W-1:0] req_value,
   input logic [sst_pkg::IDX_W-1:0]         req_index,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sst_pkg::STAT_W-1:0]        rsp_status,
   input logic [sst_pkg::IDX_W-1:0]         rsp_position,
   input logic signed [sst_pkg::ELEM_W-1:0] rsp_element,
   input logic [sst_pkg::CNT_W-1:0]         rsp_count
);
   import sst_pkg::*;

   // A failed request reports no position
   `SST_ASSERT_NOW(a_pos_zero, clock, reset,
      rsp_valid && (rsp_status != STAT_OK), rsp_position == '0,
      "position set on failed request")

   // A failed request carries no element
   `SST_ASSERT_NOW(a_elem_zero, clock, reset,
      rsp_valid && (rsp_status != STAT_OK), rsp_element == '0,
      "element set on failed request")

   // A full refusal only comes with a full table
   `SST_ASSERT_NOW(a_full_count, clock, reset,
      rsp_valid && (rsp_status == STAT_FULL), rsp_count == CNT_W'(CAPACITY),
      "full status below capacity")

   // The count never passes capacity
   `SST_ASSERT_NOW(a_count_cap, clock, reset,
      rsp_valid, rsp_count <= CNT_W'(CAPACITY),
      "count above capacity")

   // A request is never taken right after another
   `SST_ASSERT_NEXT(a_no_b2b, clock, reset,
      req_valid && req_ready, !req_ready,
      "request taken on consecutive cycles")

endmodule

bind sorted_set_table sst_checker u_sst_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for sorted_set_table: a directed table, then random requests.
// Replies are predicted in-bench and checked in order. Depends on sst_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import sst_pkg::*;

   // Kind code with no operation behind it
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1876;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [IDX_W-1:0]         position;
      logic signed [ELEM_W-1:0] element;
      logic [CNT_W-1:0]         count;
   } table_reply_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [ELEM_W-1:0] value;
      logic [IDX_W-1:0]         index;
      logic                     typed;
      table_reply_type          reply;
   } stim_row_type;

   localparam table_reply_type NO_REPLY = '0;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind = KIND_READ;
   logic signed [ELEM_W-1:0] req_value = '0;
   logic [IDX_W-1:0]         req_index = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic [IDX_W-1:0]         rsp_position;
   logic signed [ELEM_W-1:0] rsp_element;
   logic [CNT_W-1:0]         rsp_count;

   // Typed-in reply that travels with the request being offered
   logic                     row_typed = 1'b0;
   table_reply_type          row_reply = '0;

   // Shadow of the stored set and outstanding replies
   logic signed [ELEM_W-1:0] shadow_set [CAPACITY];
   int                       shadow_fill = 0;
   table_reply_type          pending_replies [$];
   logic signed [ELEM_W-1:0] sent_values [$];

   int                       error_count = 0;
   int                       cycle_count = 0;
   bit                       steady = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{KIND_READ,   32'sh0000_0000, 6'd0,  1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd0}},
      '{KIND_FIND,   32'sh0000_0000, 6'd5,  1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd0}},
      '{KIND_SPARE,  32'sh0000_0005, 6'd3,  1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd0}},
      '{KIND_INSERT, 32'sh7FFF_FFFF, 6'd63, 1'b1, '{STAT_OK,   6'd0, 32'sh0, 7'd1}},
      '{KIND_INSERT, 32'sh8000_0000, 6'd0,  1'b1, '{STAT_OK,   6'd0, 32'sh0, 7'd2}},
      '{KIND_INSERT, 32'sh7FFF_FFFF, 6'd0,  1'b1, '{STAT_DUP,  6'd0, 32'sh0, 7'd2}},
      '{KIND_INSERT, 32'sh8000_0000, 6'd0,  1'b1, '{STAT_DUP,  6'd0, 32'sh0, 7'd2}},
      '{KIND_READ,   32'shFFFF_FFFF, 6'd0,  1'b1,
        '{STAT_OK, 6'd0, 32'sh8000_0000, 7'd2}},
      '{KIND_READ,   32'sh0000_0000, 6'd1,  1'b1,
        '{STAT_OK, 6'd0, 32'sh7FFF_FFFF, 7'd2}},
      '{KIND_READ,   32'sh0000_0000, 6'd2,  1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd2}},
      '{KIND_READ,   32'sh1234_5678, 6'd63, 1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd2}},
      '{KIND_FIND,   32'sh8000_0000, 6'd63, 1'b1, '{STAT_OK,   6'd0, 32'sh0, 7'd2}},
      '{KIND_FIND,   32'sh7FFF_FFFF, 6'd0,  1'b1, '{STAT_OK,   6'd1, 32'sh0, 7'd2}},
      '{KIND_INSERT, 32'sh0000_0000, 6'd0,  1'b1, '{STAT_OK,   6'd1, 32'sh0, 7'd3}},
      '{KIND_INSERT, 32'shFFFF_FFFF, 6'd0,  1'b1, '{STAT_OK,   6'd1, 32'sh0, 7'd4}},
      '{KIND_INSERT, 32'sh0000_0001, 6'd0,  1'b1, '{STAT_OK,   6'd3, 32'sh0, 7'd5}},
      '{KIND_FIND,   32'sh7FFF_FFFF, 6'd0,  1'b1, '{STAT_OK,   6'd4, 32'sh0, 7'd5}},
      '{KIND_FIND,   32'sh0000_0002, 6'd0,  1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd5}},
      '{KIND_SPARE,  32'shFFFF_FFFF, 6'd63, 1'b1, '{STAT_MISS, 6'd0, 32'sh0, 7'd5}},
      '{KIND_READ,   32'shA5A5_A5A5, 6'd4,  1'b1,
        '{STAT_OK, 6'd0, 32'sh7FFF_FFFF, 7'd5}},
      '{KIND_INSERT, 32'sh8000_0001, 6'd0,  1'b0, NO_REPLY},
      '{KIND_INSERT, 32'sh7FFF_FFFE, 6'd0,  1'b0, NO_REPLY},
      '{KIND_READ,   32'sh0000_0000, 6'd5,  1'b0, NO_REPLY},
      '{KIND_FIND,   32'sh8000_0001, 6'd0,  1'b0, NO_REPLY}
   };

   sorted_set_table dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_index    (req_index),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Apply one request to the shadow set and return the reply it earns
   function automatic table_reply_type apply_table_op(input logic [KIND_W-1:0] kind,
                                                      input logic signed [ELEM_W-1:0] value,
                                                      input logic [IDX_W-1:0] index);
      table_reply_type r;
      int              hit;
      int              slot;
      r   = '0;
      hit = -1;
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_set[i] == value) hit = i;
      end
      case (kind)
         KIND_INSERT: begin
            if (hit >= 0) begin
               r.status = STAT_DUP;
            end else if (shadow_fill >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               // shift larger entries up one slot
               slot = shadow_fill;
               while (slot > 0 && shadow_set[slot-1] > value) begin
                  shadow_set[slot] = shadow_set[slot-1];
                  slot--;
               end
               shadow_set[slot] = value;
               shadow_fill++;
               r.position = IDX_W'(slot);
            end
         end
         KIND_FIND: begin
            if (hit >= 0) r.position = IDX_W'(hit);
            else r.status = STAT_MISS;
         end
         KIND_READ: begin
            if (int'(index) < shadow_fill) r.element = shadow_set[index];
            else r.status = STAT_MISS;
         end
         default: r.status = STAT_MISS;
      endcase
      r.count = CNT_W'(shadow_fill);
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // Predict on each accepted request, then check each accepted reply
   always @(posedge clock) begin
      table_reply_type want;
      table_reply_type got;
      if (!reset && req_valid && req_ready) begin
         want = apply_table_op(req_kind, req_value, req_index);
         if (row_typed) want = row_reply;
         pending_replies.push_back(want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_position, rsp_element, rsp_count};
         if (pending_replies.size() == 0) begin
            flag_mismatch("reply with no request outstanding");
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.position !== want.position)
               flag_mismatch($sformatf("position %0d, want %0d",
                                       got.position, want.position));
            if (got.element !== want.element)
               flag_mismatch($sformatf("element %0d, want %0d",
                                       got.element, want.element));
            if (got.count !== want.count)
               flag_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
         end
      end
   end

   // Stall the reply side at random, except in the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 28);
   end

   // Bound the run
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one request after a random gap and hold it until taken
   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [ELEM_W-1:0] value,
                                input logic [IDX_W-1:0] index,
                                input logic typed,
                                input table_reply_type reply);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(0, 99) < 28) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_index <= index;
      row_typed <= typed;
      row_reply <= reply;
      do @(posedge clock); while (!req_ready);
   endtask

   // New value: mostly wide random, some neighbors of sent values, some near the extremes or near zero
   function automatic logic signed [ELEM_W-1:0] fresh_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70 || sent_values.size() == 0) return $urandom;
      if (pick < 85)
         return sent_values[$urandom_range(0, sent_values.size() - 1)]
                + ($urandom_range(0, 1) ? 1 : -1);
      case ($urandom_range(0, 2))
         0: return 32'sh8000_0000 + $urandom_range(0, 15);
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 15);
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   initial begin
      int                       pick;
      int                       known;
      logic [KIND_W-1:0]        kind;
      logic signed [ELEM_W-1:0] value;
      logic [IDX_W-1:0]         index;

      // hold reset, then release it
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == KIND_INSERT)
            sent_values.push_back(directed_rows[i].value);
         issue_request(directed_rows[i].kind, directed_rows[i].value,
                       directed_rows[i].index, directed_rows[i].typed,
                       directed_rows[i].reply);
      end

      // hold off until every reply is back
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);

      // random requests; the set grows until full and stays full
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 700 && n < 1000);
         pick   = $urandom_range(0, 99);
         value  = $urandom;
         index  = IDX_W'($urandom_range(0, 63));
         known  = (sent_values.size() < CAPACITY) ? sent_values.size() : CAPACITY - 1;
         if (pick < 6) begin
            kind  = KIND_INSERT;
            value = fresh_value();
            sent_values.push_back(value);
         end else if (pick < 16) begin
            kind  = KIND_INSERT;
            value = sent_values[$urandom_range(0, sent_values.size() - 1)];
         end else if (pick < 36) begin
            kind  = KIND_FIND;
            value = sent_values[$urandom_range(0, sent_values.size() - 1)];
         end else if (pick < 48) begin
            kind  = KIND_FIND;
            value = fresh_value();
         end else if (pick < 70) begin
            kind  = KIND_READ;
            index = IDX_W'($urandom_range(0, known));
         end else if (pick < 94) begin
            kind  = KIND_READ;
         end else begin
            kind  = KIND_SPARE;
         end
         issue_request(kind, value, index, 1'b0, NO_REPLY);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // drain outstanding replies
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sst_ctrl.sv
rtl/sorted_set_table.sv
rtl/sst_checker.sv
sim/testbench.sv
